>>> sv/sgmf_pkg.sv
// Shared constants and types for the mirrored Savitzky-Golay FIR core.
package sgmf_pkg;

    localparam int MAX_TAPS        = 31;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_BITS      = 24;
    localparam int COEFF_FRAC_BITS = 16;
    localparam int OUT_BITS        = 32;
    localparam int TAP_W           = $clog2(MAX_TAPS);
    localparam int SEEN_W          = 6;
    localparam int SEEN_MAX        = (1 << SEEN_W) - 1;
    localparam int PROD_W          = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_W           = PROD_W + 12;
    localparam int Q_W             = ACC_W - COEFF_FRAC_BITS;
    localparam int APB_AW          = 3;

    localparam logic [0:0] OP_COEFF  = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;

    localparam logic [0:0] REG_WINDOW = 1'b0;
    localparam logic [0:0] REG_ENABLE = 1'b1;

    typedef struct packed {
        logic [4:0] window_size;
        logic       filter_enable;
    } t_cfg;

    typedef struct packed {
        logic vld;
        logic first;
    } t_issue;

    typedef struct packed {
        logic [TAP_W-1:0] k;
        logic [TAP_W-1:0] off;
        logic             ok;
    } t_rd;

endpackage

>>> sv/sgmf_apb.sv
// APB register file: window size and filter enable.
module sgmf_apb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sgmf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sgmf_pkg::t_cfg             o_cfg
);
    import sgmf_pkg::*;

    logic [4:0] r_window;
    logic       r_enable;
    logic       c_wr;

    assign pready = 1'b1;
    assign c_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 5'd3;
            r_enable <= 1'b0;
        end else if (c_wr) begin
            unique case (paddr[2])
                REG_WINDOW: r_window <= pwdata[4:0];
                REG_ENABLE: r_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW: prdata = {27'd0, r_window};
            REG_ENABLE: prdata = {31'd0, r_enable};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg.window_size   = r_window;
    assign o_cfg.filter_enable = r_enable;

endmodule

>>> sv/sgmf_store.sv
// Coefficient registers and sample history shift line with registered tap read.
module sgmf_store (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_coef_we,
    input  logic [sgmf_pkg::TAP_W-1:0]           i_coef_idx,
    input  logic signed [sgmf_pkg::COEFF_BITS-1:0]  i_coef_val,
    input  logic                                 i_shift,
    input  logic signed [sgmf_pkg::SAMPLE_BITS-1:0] i_samp,
    input  sgmf_pkg::t_rd                        i_rd,
    output logic signed [sgmf_pkg::COEFF_BITS-1:0]  o_coef,
    output logic signed [sgmf_pkg::SAMPLE_BITS-1:0] o_samp
);
    import sgmf_pkg::*;

    logic signed [COEFF_BITS-1:0]  r_coef [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_hist [MAX_TAPS];
    logic signed [COEFF_BITS-1:0]  r_coef_q;
    logic signed [SAMPLE_BITS-1:0] r_samp_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_coef_we) begin
            r_coef[i_coef_idx] <= i_coef_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_shift) begin
            r_hist[0] <= i_samp;
            for (int i = 1; i < MAX_TAPS; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef_q <= r_coef[i_rd.k];
        r_samp_q <= i_rd.ok ? r_hist[i_rd.off] : '0;
    end

    assign o_coef = r_coef_q;
    assign o_samp = r_samp_q;

endmodule

>>> sv/sgmf_mac.sv
// Shared multiply-accumulate unit with round, shift and saturate.
module sgmf_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sgmf_pkg::t_issue                        i_issue,
    input  logic signed [sgmf_pkg::COEFF_BITS-1:0]  i_coef,
    input  logic signed [sgmf_pkg::SAMPLE_BITS-1:0] i_samp,
    output logic                                    o_busy,
    output logic signed [sgmf_pkg::OUT_BITS-1:0]    o_filtered,
    output logic                                    o_saturated
);
    import sgmf_pkg::*;

    t_issue                   r_iss1;
    t_issue                   r_iss2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  c_rnd;
    logic signed [Q_W-1:0]    c_q;
    logic                     c_hi;
    logic                     c_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss1 <= '0;
            r_iss2 <= '0;
        end else begin
            r_iss1 <= i_issue;
            r_iss2 <= r_iss1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_iss1.vld) begin
            r_prod <= i_coef * i_samp;
        end
        if (r_iss2.vld) begin
            r_acc <= (r_iss2.first ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_iss1.vld || r_iss2.vld;

    always_comb begin
        c_rnd = r_acc + (ACC_W'(1) <<< (COEFF_FRAC_BITS - 1));
        c_q   = c_rnd[ACC_W-1:COEFF_FRAC_BITS];
        c_hi  = !c_q[Q_W-1] && (c_q[Q_W-2:OUT_BITS-1] != '0);
        c_lo  = c_q[Q_W-1] && (c_q[Q_W-2:OUT_BITS-1] != '1);
        o_saturated = c_hi || c_lo;
        if (c_hi) begin
            o_filtered = {1'b0, {(OUT_BITS-1){1'b1}}};
        end else if (c_lo) begin
            o_filtered = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            o_filtered = c_q[OUT_BITS-1:0];
        end
    end

endmodule

>>> sv/savgol_mirror_fir_core.sv
// Top level: mirrored Savitzky-Golay FIR, sequencer around one shared MAC.
//
// Input channel (i_in_valid / o_in_stall): operation 0 loads a coefficient
// into tap coeff_index, operation 1 presents a sample. APB registers set the
// window size (0, byte 0) and filter enable (1, byte 4); write them while idle.
// Output channel (o_out_valid / i_out_stall) carries filtered, saturated and
// last_out from an output register.
// One item is taken at a time; o_in_stall is high while it is worked on.
// A coefficient is written when it is accepted; a pass-through sample goes
// through S_PASS to the output register. Each filtered output walks the
// window through the single multiplier, one tap per cycle, w the taps in
// use (3..31). A sample gives 0 or 1 outputs; a sample marked last gives
// up to h + 1 (h = w / 2). Outputs lag the input by h samples.
// While the receiver stalls, the finished result waits in the output
// register and the sequencer holds until it is taken.
// Reset (synchronous, active low) clears coefficients, history and the
// sample count, and sets window 3 with filtering disabled.
module savgol_mirror_fir_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_operation,
    input  logic [sgmf_pkg::TAP_W-1:0]              i_coeff_index,
    input  logic signed [sgmf_pkg::COEFF_BITS-1:0]  i_coeff_value,
    input  logic signed [sgmf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                    i_last,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [sgmf_pkg::OUT_BITS-1:0]    o_filtered,
    output logic                                    o_saturated,
    output logic                                    o_last_out,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sgmf_pkg::APB_AW-1:0]             paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import sgmf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    t_cfg   c_cfg;
    t_issue c_issue;
    t_rd    c_rd;

    logic [2:0]        r_state, n_state;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [SEEN_W-1:0] r_j, n_j;
    logic [SEEN_W-1:0] r_pos, n_pos;
    logic [SEEN_W-1:0] r_end, n_end;
    logic [TAP_W-1:0]  r_k, n_k;
    logic              r_last, n_last;
    logic signed [SAMPLE_BITS-1:0] r_samp, n_samp;

    logic                       r_out_vld, n_out_vld;
    logic signed [OUT_BITS-1:0] r_filtered, n_filtered;
    logic                       r_sat, n_sat;
    logic                       r_last_out, n_last_out;

    logic [TAP_W-1:0]  c_taps;
    logic [TAP_W-2:0]  c_h;
    logic              c_acc;
    logic              c_out_free;
    logic              c_coef_we;
    logic              c_shift;
    logic [SEEN_W-1:0] c_seen_inc;
    logic [SEEN_W-1:0] c_j_new;
    logic              c_mac_busy;
    logic signed [OUT_BITS-1:0] c_mac_val;
    logic              c_mac_sat;
    logic signed [COEFF_BITS-1:0]  c_coef_q;
    logic signed [SAMPLE_BITS-1:0] c_samp_q;

    logic signed [8:0] c_jj, c_i0, c_i1, c_i2, c_i3, c_off;

    sgmf_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (c_cfg)
    );

    sgmf_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef_we  (c_coef_we),
        .i_coef_idx (i_coeff_index),
        .i_coef_val (i_coeff_value),
        .i_shift    (c_shift),
        .i_samp     (i_sample),
        .i_rd       (c_rd),
        .o_coef     (c_coef_q),
        .o_samp     (c_samp_q)
    );

    sgmf_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (c_issue),
        .i_coef      (c_coef_q),
        .i_samp      (c_samp_q),
        .o_busy      (c_mac_busy),
        .o_filtered  (c_mac_val),
        .o_saturated (c_mac_sat)
    );

    assign c_taps     = (c_cfg.window_size < 5'd3) ? 5'd3 : (c_cfg.window_size | 5'd1);
    assign c_h        = c_taps[TAP_W-1:1];
    assign o_in_stall = (r_state != S_IDLE);
    assign c_acc      = i_in_valid && !o_in_stall;
    assign c_out_free = !r_out_vld || !i_out_stall;
    assign c_coef_we  = c_acc && (i_operation == OP_COEFF)
                        && (i_coeff_index < TAP_W'(MAX_TAPS));
    assign c_shift    = c_acc && (i_operation == OP_SAMPLE) && c_cfg.filter_enable;
    assign c_seen_inc = (r_seen == SEEN_W'(SEEN_MAX)) ? r_seen : r_seen + 1'b1;
    assign c_j_new    = c_seen_inc - 1'b1;

    // Mirrored and clamped history offset for tap r_k of position r_pos.
    always_comb begin
        c_jj = $signed({3'b000, r_j});
        c_i0 = $signed({3'b000, r_pos}) - $signed({5'b00000, c_h})
               + $signed({4'b0000, r_k});
        c_i1 = (c_i0 < 0) ? -c_i0 : c_i0;
        c_i2 = (r_last && c_i1 > c_jj) ? (c_jj <<< 1) - c_i1 : c_i1;
        if (c_i2 < 0) begin
            c_i3 = '0;
        end else if (c_i2 > c_jj) begin
            c_i3 = c_jj;
        end else begin
            c_i3 = c_i2;
        end
        c_off    = c_jj - c_i3;
        c_rd.k   = r_k;
        c_rd.off = c_off[TAP_W-1:0];
        c_rd.ok  = (c_off < 9'sd31);
    end

    assign c_issue.vld   = (r_state == S_MAC);
    assign c_issue.first = (r_k == '0);

    always_comb begin
        n_state    = r_state;
        n_seen     = r_seen;
        n_j        = r_j;
        n_pos      = r_pos;
        n_end      = r_end;
        n_k        = r_k;
        n_last     = r_last;
        n_samp     = r_samp;
        n_out_vld  = r_out_vld && i_out_stall;
        n_filtered = r_filtered;
        n_sat      = r_sat;
        n_last_out = r_last_out;
        unique case (r_state)
            S_IDLE: begin
                if (c_acc && i_operation == OP_SAMPLE) begin
                    n_samp = i_sample;
                    n_last = i_last;
                    if (!c_cfg.filter_enable) begin
                        n_state = S_PASS;
                    end else begin
                        n_j = c_j_new;
                        n_k = '0;
                        if (i_last) begin
                            n_seen  = '0;
                            n_pos   = (c_j_new >= SEEN_W'(c_h)) ? c_j_new - SEEN_W'(c_h) : '0;
                            n_end   = c_j_new;
                            n_state = S_MAC;
                        end else begin
                            n_seen = c_seen_inc;
                            n_pos  = c_j_new - SEEN_W'(c_h);
                            n_end  = c_j_new - SEEN_W'(c_h);
                            if (c_j_new >= SEEN_W'(c_h)) begin
                                n_state = S_MAC;
                            end
                        end
                    end
                end
            end
            S_PASS: begin
                if (c_out_free) begin
                    n_out_vld  = 1'b1;
                    n_filtered = OUT_BITS'(r_samp);
                    n_sat      = 1'b0;
                    n_last_out = r_last;
                    n_state    = S_IDLE;
                end
            end
            S_MAC: begin
                n_k = r_k + 1'b1;
                if (r_k == c_taps - 1'b1) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!c_mac_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (c_out_free) begin
                    n_out_vld  = 1'b1;
                    n_filtered = c_mac_val;
                    n_sat      = c_mac_sat;
                    n_last_out = r_last && (r_pos == r_j);
                    n_k        = '0;
                    if (r_pos == r_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seen    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seen    <= n_seen;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_pos      <= n_pos;
        r_end      <= n_end;
        r_k        <= n_k;
        r_last     <= n_last;
        r_samp     <= n_samp;
        r_filtered <= n_filtered;
        r_sat      <= n_sat;
        r_last_out <= n_last_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_filtered  = r_filtered;
    assign o_saturated = r_sat;
    assign o_last_out  = r_last_out;

endmodule

>>> test/tb_savgol_mirror_fir_core.sv
// Testbench for savgol_mirror_fir_core: directed and random items against a predictor.
`timescale 1ns / 1ps

module tb_savgol_mirror_fir_core;
    import sgmf_pkg::*;

    typedef struct {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       saturated;
        logic                       last_out;
    } t_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_operation;
    logic [TAP_W-1:0]              i_coeff_index;
    logic signed [COEFF_BITS-1:0]  i_coeff_value;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_last;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [OUT_BITS-1:0]    o_filtered;
    logic                          o_saturated;
    logic                          o_last_out;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_AW-1:0]             paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // predictor state
    longint  coeffs [MAX_TAPS];
    longint  history [MAX_TAPS];
    int      seen_count;
    logic [4:0] win_reg;
    logic    enable_reg;

    t_result pending_results [$];
    int      mismatches;
    bit      calm;

    savgol_mirror_fir_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_filtered    (o_filtered),
        .o_saturated   (o_saturated),
        .o_last_out    (o_last_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (calm) begin
            return 0;
        end
        if (r < 6) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic int taps_active();
        int w;
        w = int'(win_reg);
        if (w < 3) w = 3;
        if ((w & 1) == 0) w++;
        if (w > ((MAX_TAPS - 1) | 1)) w = (MAX_TAPS - 1) | 1;
        return w;
    endfunction

    function automatic longint window_acc(input int pos, input int newest, input bit at_end);
        int     w;
        int     h;
        int     idx;
        int     off;
        longint acc;
        w = taps_active();
        h = w / 2;
        acc = 0;
        for (int k = 0; k < w; k++) begin
            idx = pos - h + k;
            if (idx < 0) idx = -idx;
            if (at_end && idx > newest) idx = 2 * newest - idx;
            if (idx < 0) idx = 0;
            if (idx > newest) idx = newest;
            off = newest - idx;
            if (off >= 0 && off < MAX_TAPS) begin
                acc += coeffs[k] * history[off];
            end
        end
        return acc;
    endfunction

    function automatic t_result round_sat(input longint acc, input bit is_last);
        t_result r;
        longint  q;
        q = (acc + (longint'(1) << (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
        r.saturated = 1'b0;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.filtered = q[OUT_BITS-1:0];
        r.last_out = is_last;
        return r;
    endfunction

    task automatic clear_predictor();
        for (int i = 0; i < MAX_TAPS; i++) begin
            coeffs[i] = 0;
            history[i] = 0;
        end
        seen_count = 0;
        win_reg = 5'd3;
        enable_reg = 1'b0;
    endtask

    task automatic predict_outputs(input logic op, input logic [TAP_W-1:0] idx,
                                   input logic signed [COEFF_BITS-1:0] cval,
                                   input logic signed [SAMPLE_BITS-1:0] smp,
                                   input logic lst);
        t_result r;
        int      j;
        int      h;
        int      first;
        if (op == OP_COEFF) begin
            if (idx < MAX_TAPS) coeffs[idx] = longint'(cval);
            return;
        end
        if (!enable_reg) begin
            r.filtered = OUT_BITS'(smp);
            r.saturated = 1'b0;
            r.last_out = lst;
            pending_results.push_back(r);
            return;
        end
        for (int i = MAX_TAPS - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = longint'(smp);
        if (seen_count < SEEN_MAX) seen_count++;
        j = seen_count - 1;
        h = taps_active() / 2;
        if (!lst) begin
            if (j >= h) pending_results.push_back(round_sat(window_acc(j - h, j, 1'b0), 1'b0));
            return;
        end
        first = (j >= h) ? j - h : 0;
        for (int pos = first; pos <= j; pos++) begin
            pending_results.push_back(round_sat(window_acc(pos, j, 1'b1), pos == j));
        end
        seen_count = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic send_item(input logic op, input logic [TAP_W-1:0] idx,
                             input logic signed [COEFF_BITS-1:0] cval,
                             input logic signed [SAMPLE_BITS-1:0] smp, input logic lst);
        int gap;
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_coeff_index <= idx;
        i_coeff_value <= cval;
        i_sample      <= smp;
        i_last        <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_outputs(op, idx, cval, smp, lst);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_coeff(input logic [TAP_W-1:0] idx, input logic signed [COEFF_BITS-1:0] v);
        send_item(OP_COEFF, idx, v, SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic lst);
        send_item(OP_SAMPLE, TAP_W'($urandom), COEFF_BITS'($urandom), s, lst);
    endtask

    task automatic drain_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] which, input logic [31:0] value);
        drain_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_WINDOW) win_reg = value[4:0];
        else enable_reg = value[0];
        @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEFF_BITS-1:0] rand_coeff();
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return COEFF_BITS'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_results
        t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_filtered, 32'h0);
            end else begin
                e = pending_results.pop_front();
                if (o_filtered !== e.filtered) report_mismatch("filtered", o_filtered, e.filtered);
                if (o_saturated !== e.saturated)
                    report_mismatch("saturated", 32'(o_saturated), 32'(e.saturated));
                if (o_last_out !== e.last_out)
                    report_mismatch("last_out", 32'(o_last_out), 32'(e.last_out));
            end
        end
    end

    // receiver stall pattern
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            i_out_stall <= 1'b0;
            repeat (1 + $urandom_range(0, 12)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic test_passthrough();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b1);
    endtask

    task automatic test_coeff_extremes();
        send_coeff(5'd0, 24'sh7FFFFF);
        send_coeff(5'd1, 24'sh800000);
        send_coeff(5'd2, 24'sh010000);
        send_coeff(5'd30, 24'sh7FFFFF);
        send_coeff(5'd31, 24'sh800000);
    endtask

    task automatic test_short_signals();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_WINDOW, 32'd0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh1234, 1'b1);
    endtask

    task automatic test_wide_window();
        write_reg(REG_WINDOW, 32'd31);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        write_reg(REG_WINDOW, 32'd30);
        send_sample(16'sh4000, 1'b0);
        send_sample(-16'sd3, 1'b1);
    endtask

    task automatic test_window_change();
        write_reg(REG_WINDOW, 32'd5);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd200, 1'b0);
        send_sample(16'sd300, 1'b0);
        write_reg(REG_WINDOW, 32'd2);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd5, 1'b1);
    endtask

    task automatic test_random_signals();
        int sent;
        int len;
        int ncoef;
        logic [TAP_W-1:0] idx;
        logic lst;
        sent = 0;
        while (sent < 400) begin
            calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 5))
                0: write_reg(REG_WINDOW, $urandom_range(0, 2));
                1: write_reg(REG_WINDOW, 32'd31);
                2: write_reg(REG_WINDOW, 32'd30);
                default: write_reg(REG_WINDOW, $urandom);
            endcase
            write_reg(REG_ENABLE, ($urandom_range(0, 7) != 0) ? 32'd1 : 32'd0);
            ncoef = $urandom_range(0, 8);
            for (int c = 0; c < ncoef; c++) begin
                idx = ($urandom_range(0, 15) == 0) ? 5'd31 : 5'($urandom_range(0, MAX_TAPS - 1));
                send_coeff(idx, rand_coeff());
                if (idx != 5'd31) sent++;
            end
            case ($urandom_range(0, 9))
                0: len = $urandom_range(64, 75);
                1, 2, 3: len = $urandom_range(1, 4);
                default: len = $urandom_range(5, 20);
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_coeff(5'($urandom_range(0, MAX_TAPS - 1)), rand_coeff());
                    sent++;
                end
                if (i > 0 && $urandom_range(0, 39) == 0) write_reg(REG_WINDOW, $urandom);
                if (i > 0 && $urandom_range(0, 59) == 0) write_reg(REG_ENABLE, $urandom);
                // occasionally drop the last marker so the signal runs on
                lst = (i == len - 1) && ($urandom_range(0, 9) != 0);
                send_sample(rand_sample(), lst);
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_COEFF;
        i_coeff_index = '0;
        i_coeff_value = '0;
        i_sample      = '0;
        i_last        = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        calm          = 1'b0;
        clear_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_coeff_extremes();
        test_short_signals();
        test_wide_window();
        test_window_change();
        test_random_signals();

        drain_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
